### rtl/core/adc_ema_pkg.sv
// Package: command codes, field widths and payload layouts of the scan filter.
package adc_ema_pkg;

  // Command codes carried on in_tuser
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_SAMPLE = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_RSVD   = 2'd3;

  localparam int PIN_W    = 5;
  localparam int SHIFT_W  = 5;
  localparam int SAMPLE_W = 12;
  localparam int ACC_W    = 32;
  localparam int READ_W   = 16;

  // Sample alignment inside the accumulator
  localparam int SAMPLE_ALIGN = 19;

  // Reset shifts of the slot filter and of the pin read path
  localparam logic [SHIFT_W-1:0] FSH_RESET = 5'd9;
  localparam logic [SHIFT_W-1:0] OSH_RESET = 5'd15;

  // Input payload, first field highest; 27 bits padded to 32
  typedef struct packed {
    logic [4:0]          pad;
    logic [SAMPLE_W-1:0] sample;
    logic [SHIFT_W-1:0]  out_shift;
    logic [SHIFT_W-1:0]  filter_shift;
    logic [PIN_W-1:0]    pin;
  } in_data_t;

  // Result payload, first field highest; 22 bits padded to 24
  typedef struct packed {
    logic [1:0]        pad;
    logic              accepted;
    logic [READ_W-1:0] read_value;
    logic [PIN_W-1:0]  next_pin;
  } out_data_t;

endpackage

### rtl/core/adc_scan_ema_filter.sv
// Top level: scan list, per-pin shift low-pass accumulators and result register.
// Output: the result of an accepted transaction is registered and driven on out_*.
// Throughput: one transaction per cycle; the single read-modify-write of one
// accumulator and the output register set the rate, and in_tready stays high
// while the result register is empty or being taken.
// Reset (rst_n low, synchronous): scan list empty, accumulators zero, filter
// shifts 9, read shifts 15, no result pending.
module adc_scan_ema_filter #(
  parameter int NUM_CHANNELS = 18
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // pin[4:0], filter_shift[9:5], out_shift[14:10],
                                  // sample[26:15], zero pad[31:27]
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // next_pin[4:0], read_value[20:5], accepted[21],
                                  // zero pad[23:22]
);
  import adc_ema_pkg::*;

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CNT_W = $clog2(NUM_CHANNELS + 1);
  localparam logic [PIN_W:0] NCH_P = (PIN_W + 1)'(NUM_CHANNELS);
  localparam logic [CNT_W-1:0] NCH_C = CNT_W'(NUM_CHANNELS);

  // State
  logic [ACC_W-1:0]   acc_r      [NUM_CHANNELS];
  logic [PIN_W-1:0]   slot_pin_r [NUM_CHANNELS];
  logic [SHIFT_W-1:0] slot_fsh_r [NUM_CHANNELS];
  logic [SHIFT_W-1:0] pin_osh_r  [NUM_CHANNELS];
  logic [IDX_W-1:0]   slot_pos_r, slot_pos_nxt;
  logic [CNT_W-1:0]   slot_cnt_r, slot_cnt_nxt;
  // Copy of the current slot's contents, so the scan list has one read port
  logic [PIN_W-1:0]   cur_pin_r, cur_pin_nxt;
  logic [SHIFT_W-1:0] cur_fsh_r, cur_fsh_nxt;

  logic      out_valid_r;
  out_data_t out_data_r, out_data_nxt;

  in_data_t  in_d;
  logic      in_fire;
  logic      pin_ok, add_ok, cur_ok;
  logic [IDX_W-1:0]   pin_idx, cur_idx, acc_idx, add_idx;
  logic [ACC_W-1:0]   acc_rd, target, diff, acc_new;
  logic [SHIFT_W-1:0] osh_rd;
  logic [CNT_W:0]     pos_inc;
  logic               acc_we;

  assign in_d      = in_data_t'(in_tdata);
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Decode indexes and range checks
  assign pin_ok  = {1'b0, in_d.pin} < NCH_P;
  assign cur_ok  = {1'b0, cur_pin_r} < NCH_P;
  assign pin_idx = IDX_W'(in_d.pin);
  assign cur_idx = IDX_W'(cur_pin_r);
  assign add_idx = IDX_W'(slot_cnt_r);
  assign add_ok  = (slot_cnt_r < NCH_C) && pin_ok;
  assign acc_idx = (in_tuser == CMD_SAMPLE) ? cur_idx : pin_idx;
  assign acc_rd  = acc_r[acc_idx];
  assign osh_rd  = pin_osh_r[pin_idx];

  // Filter update: acc += ((sample << 19) - acc) >>> shift
  assign target  = ACC_W'(in_d.sample) << SAMPLE_ALIGN;
  assign diff    = target - acc_rd;
  assign acc_new = acc_rd + ACC_W'($signed(diff) >>> cur_fsh_r);

  // Advance the scan position with wrap at the slot count
  assign pos_inc = (CNT_W + 1)'(slot_pos_r) + (CNT_W + 1)'(1);

  always_comb begin
    logic [ACC_W-1:0] shifted;
    shifted      = ACC_W'($signed(acc_rd) >>> osh_rd);
    slot_pos_nxt = slot_pos_r;
    slot_cnt_nxt = slot_cnt_r;
    cur_pin_nxt  = cur_pin_r;
    cur_fsh_nxt  = cur_fsh_r;
    acc_we       = 1'b0;
    out_data_nxt = '0;
    case (in_tuser)
      CMD_ADD: begin
        if (add_ok) begin
          slot_cnt_nxt = slot_cnt_r + CNT_W'(1);
          out_data_nxt.accepted = 1'b1;
          // Keep the current-slot copy coherent when its slot is written
          if (add_idx == slot_pos_r) begin
            cur_pin_nxt = in_d.pin;
            cur_fsh_nxt = in_d.filter_shift;
          end
        end
      end
      CMD_SAMPLE: begin
        acc_we = cur_ok;
        if (pos_inc >= (CNT_W + 1)'(slot_cnt_r) ||
            pos_inc >= (CNT_W + 1)'(NUM_CHANNELS)) begin
          slot_pos_nxt = '0;
        end else begin
          slot_pos_nxt = IDX_W'(pos_inc);
        end
        cur_pin_nxt = slot_pin_r[slot_pos_nxt];
        cur_fsh_nxt = slot_fsh_r[slot_pos_nxt];
        out_data_nxt.next_pin = cur_pin_nxt;
      end
      CMD_READ: begin
        if (pin_ok) begin
          out_data_nxt.read_value = shifted[READ_W-1:0];
        end
      end
      default: begin
        out_data_nxt = '0;
      end
    endcase
  end

  // Update state on an accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        acc_r[i]      <= '0;
        slot_pin_r[i] <= '0;
        slot_fsh_r[i] <= FSH_RESET;
        pin_osh_r[i]  <= OSH_RESET;
      end
      slot_pos_r <= '0;
      slot_cnt_r <= '0;
      cur_pin_r  <= '0;
      cur_fsh_r  <= FSH_RESET;
    end else if (in_fire) begin
      if (in_tuser == CMD_ADD && add_ok) begin
        slot_pin_r[add_idx] <= in_d.pin;
        slot_fsh_r[add_idx] <= in_d.filter_shift;
        pin_osh_r[pin_idx]  <= in_d.out_shift;
      end
      if (acc_we) begin
        acc_r[cur_idx] <= acc_new;
      end
      slot_pos_r <= slot_pos_nxt;
      slot_cnt_r <= slot_cnt_nxt;
      cur_pin_r  <= cur_pin_nxt;
      cur_fsh_r  <= cur_fsh_nxt;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Scan position stays inside the list, or at zero when it is empty
  a_pos_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    (slot_pos_r == '0) || ((CNT_W + 1)'(slot_pos_r) < (CNT_W + 1)'(slot_cnt_r)))
    else $error("scan position beyond slot count");

  // Slot count never exceeds the channel count
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    slot_cnt_r <= NCH_C)
    else $error("slot count overflow");

  // Current-slot copy matches the scan list
  a_cur_coherent: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_pin_r == slot_pin_r[slot_pos_r]) && (cur_fsh_r == slot_fsh_r[slot_pos_r]))
    else $error("current slot copy out of step");

  // Reserved command leaves an all-zero result
  a_rsvd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser == CMD_RSVD) |=> (out_data_r == '0))
    else $error("reserved command produced data");

  // Add on a full list changes nothing in the count and is not accepted
  a_full_add: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser == CMD_ADD && slot_cnt_r == NCH_C)
      |=> (slot_cnt_r == NCH_C) && !out_data_r.accepted)
    else $error("add accepted on full list");

endmodule
